>>> rtl/bced_pkg.sv
// Shared types and constants for the binary cross erode/dilate block.
`timescale 1ns / 1ps

package bced_pkg;

  // Default sizing
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_PASSES = 8;

  // Register field widths
  localparam int WIDTH_REG_W = 11;
  localparam int HGT_W       = 13;
  localparam int PASS_REG_W  = 4;
  localparam int LEVEL_W     = 8;
  localparam int PIX_W       = 8;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_IDX_W   = 3;

  // Rows per frame are capped here regardless of the register value
  localparam int HEIGHT_LIMIT = 4096;

  // Register reset values
  localparam logic [WIDTH_REG_W-1:0] RST_IMAGE_WIDTH    = 11'd1024;
  localparam logic [HGT_W-1:0]       RST_IMAGE_HEIGHT   = 13'd768;
  localparam logic                   RST_OPERATION_MODE = 1'b0;
  localparam logic [PASS_REG_W-1:0]  RST_PASS_COUNT     = 4'd1;
  localparam logic [LEVEL_W-1:0]     RST_BINARIZE_LEVEL = 8'd128;

  // Output pixel levels
  localparam logic [PIX_W-1:0] PIX_FG = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_BG = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 3'd0,
    REG_IMAGE_HEIGHT   = 3'd1,
    REG_OPERATION_MODE = 3'd2,
    REG_PASS_COUNT     = 3'd3,
    REG_BINARIZE_LEVEL = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    MODE_ERODE  = 1'b0,
    MODE_DILATE = 1'b1
  } morph_mode_e;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_DRAIN = 1'b1
  } item_kind_e;

  // Input transaction payload
  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel_in;
  } pix_in_t;

  // Output transaction payload
  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
  } pix_out_t;

  // Item moving between passes
  typedef struct packed {
    logic drain;
    logic fg;
    logic last;
  } stage_item_t;

  // Frame-wide controls shared by every pass
  typedef struct packed {
    logic             dilate;
    logic [HGT_W-1:0] height;
  } pass_ctl_t;

endpackage

>>> rtl/binary_cross_erode_dilate_top.sv
// Top level of the binary cross erode/dilate streaming block.
`timescale 1ns / 1ps

// Grey pixels enter in raster order, one transaction per clock unless
// stalled, and are binarized (foreground when pixel_in >= binarize_level).
// They then run through pass_count cascaded 3x3-cross erode or dilate
// passes with replicated borders; results are 0 or 255, frame_last marks
// the final pixel. Throughput is one transaction per clock in both
// directions while out_ready is held high: each pass does one read and one
// write of its own MAX_WIDTH x 2-bit line memory per transaction (the read
// is prefetched two columns ahead, with write-first forwarding for very
// narrow images). Each pass holds back one image row, so after the last
// pixel of a frame the source must send pass_count * image_width drain
// transactions (kind = 1); surplus drains are dropped. Each pass adds one
// output register on top of that row delay; passes beyond pass_count act
// as plain registers. The line memories need no clearing pass after reset.
// Write configuration only while the block is idle; out-of-range register
// values are clamped.

module binary_cross_erode_dilate_top
  import bced_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_PASSES = DEF_MAX_PASSES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pix_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pix_out_t              out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = CW + 1;
  localparam int PW = $clog2(MAX_PASSES + 1);

  // Configuration registers
  logic [WIDTH_REG_W-1:0] image_width;
  logic [HGT_W-1:0]       image_height;
  logic                   operation_mode;
  logic [PASS_REG_W-1:0]  pass_count;
  logic [LEVEL_W-1:0]     binarize_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RST_IMAGE_WIDTH;
      image_height   <= RST_IMAGE_HEIGHT;
      operation_mode <= RST_OPERATION_MODE;
      pass_count     <= RST_PASS_COUNT;
      binarize_level <= RST_BINARIZE_LEVEL;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:    image_width    <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data[HGT_W-1:0];
        REG_OPERATION_MODE: operation_mode <= cfg_data[0];
        REG_PASS_COUNT:     pass_count     <= cfg_data[PASS_REG_W-1:0];
        REG_BINARIZE_LEVEL: binarize_level <= cfg_data[LEVEL_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Clamped (effective) frame geometry and pass count
  logic [EW-1:0]    eff_width;
  logic [EW-1:0]    eff_width_m1;
  logic [HGT_W-1:0] eff_height;
  logic [PW-1:0]    eff_passes;
  pass_ctl_t        ctl;

  always_comb begin
    if (image_width == '0) begin
      eff_width = EW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      eff_width = EW'(MAX_WIDTH);
    end else begin
      eff_width = EW'(image_width);
    end
    eff_width_m1 = eff_width - EW'(1);

    if (image_height == '0) begin
      eff_height = HGT_W'(1);
    end else if (32'(image_height) > HEIGHT_LIMIT) begin
      eff_height = HGT_W'(HEIGHT_LIMIT);
    end else begin
      eff_height = image_height;
    end

    if (pass_count == '0) begin
      eff_passes = PW'(1);
    end else if (32'(pass_count) > MAX_PASSES) begin
      eff_passes = PW'(MAX_PASSES);
    end else begin
      eff_passes = PW'(pass_count);
    end

    ctl.dilate = operation_mode;
    ctl.height = eff_height;
  end

  // Pass chain: link k feeds pass k, link k+1 is its output register
  logic [MAX_PASSES:0] link_valid;
  logic [MAX_PASSES:0] link_ready;
  stage_item_t         link_item [MAX_PASSES+1];

  assign link_valid[0]      = in_valid;
  assign in_ready           = link_ready[0];
  assign link_item[0].drain = (in_data.kind == KIND_DRAIN);
  assign link_item[0].fg    = (in_data.pixel_in >= binarize_level);
  assign link_item[0].last  = 1'b0;

  for (genvar k = 0; k < MAX_PASSES; k++) begin : g_pass
    logic pass_en;
    assign pass_en = (32'(eff_passes) > k);

    bced_pass #(
      .MAX_WIDTH (MAX_WIDTH)
    ) u_pass (
      .clk       (clk),
      .rst       (rst),
      .enable    (pass_en),
      .width     (eff_width),
      .width_m1  (eff_width_m1),
      .ctl       (ctl),
      .in_valid  (link_valid[k]),
      .in_ready  (link_ready[k]),
      .in_item   (link_item[k]),
      .out_valid (link_valid[k+1]),
      .out_ready (link_ready[k+1]),
      .out_item  (link_item[k+1])
    );
  end

  // Drains that make it through every pass are swallowed here
  stage_item_t tail;
  assign tail                   = link_item[MAX_PASSES];
  assign out_valid              = link_valid[MAX_PASSES] && !tail.drain;
  assign link_ready[MAX_PASSES] = out_ready || tail.drain;
  assign out_data.pixel_out     = tail.fg ? PIX_FG : PIX_BG;
  assign out_data.frame_last    = tail.last;

  // Input back-pressure only comes from a full first pass register
  a_in_stall : assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> link_valid[1])
    else $error("input stalled with empty first pass register");

  // A blocked first pass register keeps its item
  a_pass_hold : assert property (@(posedge clk) disable iff (rst)
    link_valid[1] && !link_ready[1] |=> link_valid[1] && $stable(link_item[1]))
    else $error("first pass register changed while blocked");

  // Reset empties the pipeline
  a_reset_empty : assert property (@(posedge clk)
    rst |=> !out_valid && !link_valid[1])
    else $error("pipeline not empty after reset");

endmodule

>>> rtl/bced_pass.sv
// One morphology pass: 2-bit line memory, cross window and output register.
`timescale 1ns / 1ps

module bced_pass
  import bced_pkg::*;
#(
  parameter int  MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int CW        = $clog2(MAX_WIDTH),
  localparam int EW        = CW + 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          enable,
  input  logic [EW-1:0] width,
  input  logic [EW-1:0] width_m1,
  input  pass_ctl_t     ctl,
  input  logic          in_valid,
  output logic          in_ready,
  input  stage_item_t   in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output stage_item_t   out_item
);

  // line memory entry: [1] older row, [0] newer row, per column
  logic [1:0] line_mem [MAX_WIDTH];
  logic [1:0] rd_q;

  logic [CW-1:0]    col;
  logic [HGT_W-1:0] row;
  logic [1:0]       cur;       // entry of the current column
  logic             left_ctr;  // centre row, previous column

  logic             take, idle, busy, live_row, produce;
  logic             v, mem_en;
  logic [1:0]       wr_data;
  logic [CW-1:0]    rd_addr;
  logic [EW-1:0]    col_p1, col_a, col_b_p1, col_b;
  logic             row_inc;
  logic [HGT_W-1:0] row_p1, row_adv;
  logic [CW-1:0]    col_next;
  logic [HGT_W-1:0] row_next;
  logic             ctr, up, down, left, right, last_row, last_col, res;
  stage_item_t      res_item;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;
  assign idle     = in_item.drain && (col == '0) && (row == '0);
  assign busy     = enable && !idle;
  assign live_row = (row != '0) && (row <= ctl.height);
  assign produce  = take && (!enable || idle || live_row);
  assign v        = !in_item.drain && in_item.fg;
  assign mem_en   = take && busy;
  assign wr_data  = {cur[0], v};

  // column walk with wrap; col_b is the prefetch address two ahead
  always_comb begin
    col_p1   = {1'b0, col} + EW'(1);
    row_inc  = (col_p1 >= width);
    col_a    = row_inc ? '0 : col_p1;
    col_b_p1 = col_a + EW'(1);
    col_b    = (col_b_p1 >= width) ? '0 : col_b_p1;
    rd_addr  = col_b[CW-1:0];
    row_p1   = row + HGT_W'(1);
    row_adv  = row_inc ? row_p1 : row;
    if (row_adv > ctl.height) begin
      col_next = '0;
      row_next = '0;
    end else begin
      col_next = col_a[CW-1:0];
      row_next = row_adv;
    end
  end

  // cross window
  always_comb begin
    ctr      = cur[0];
    last_row = (row >= ctl.height);
    last_col = ({1'b0, col} >= width_m1);
    up       = (row == HGT_W'(1)) ? ctr : cur[1];
    down     = last_row ? ctr : v;
    left     = (col == '0) ? ctr : left_ctr;
    right    = last_col ? ctr : rd_q[0];
    if (ctl.dilate == MODE_DILATE) begin
      res = ctr | up | down | left | right;
    end else begin
      res = ctr & up & down & left & right;
    end
    if (!enable || idle) begin
      res_item = in_item;
    end else begin
      res_item.drain = 1'b0;
      res_item.fg    = res;
      res_item.last  = last_row && last_col;
    end
  end

  // write-first RAM: same-address read returns the new data
  always_ff @(posedge clk) begin
    if (mem_en) begin
      line_mem[col] <= wr_data;
      rd_q          <= (rd_addr == col) ? wr_data : line_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_en) begin
      cur      <= (width_m1 == '0) ? wr_data : rd_q;
      left_ctr <= cur[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (mem_en) begin
      col <= col_next;
      row <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_item <= res_item;
    end
  end

endmodule
